### rtl/urm_pkg.sv
// Shared types and constants for the ultrasonic ranger with median filter.
package urm_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int WIDTH_W    = 16;
	localparam int DIST_W     = 17;
	localparam int TICK_W     = 17;

	// distance in 1/64 cm = (width * DIST_MUL) >> DIST_SHIFT
	localparam logic [16:0] DIST_MUL   = 17'd71930;
	localparam int          DIST_SHIFT = 16;

	localparam logic [TICK_W-1:0] TRIG_LOW_TICKS = 17'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ATTEMPTS  = 3'd6;

	typedef struct packed {
		logic [15:0] timeout_us;
		logic [7:0]  trig_high_us;
		logic [16:0] gap_us;
		logic [15:0] min_width_us;
		logic [15:0] max_width_us;
		logic [1:0]  samples_wanted;
		logic [3:0]  max_attempts;
	} cfg_t;

	typedef struct packed {
		logic               trigger_level;
		logic               busy_res;
		logic               done_res;
		logic               success;
		logic [WIDTH_W-1:0] echo_width_us;
	} res_t;

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_TLOW  = 6'b000010,
		PH_THIGH = 6'b000100,
		PH_RISE  = 6'b001000,
		PH_FALL  = 6'b010000,
		PH_GAP   = 6'b100000
	} phase_t;

endpackage

### rtl/urm_if.sv
// Handshake channels of the ranger: tick input, result output, register writes.
interface urm_in_if;
	logic valid;
	logic ready;
	logic req_type;
	logic echo_level;

	modport source (output valid, output req_type, output echo_level, input ready);
	modport sink   (input valid, input req_type, input echo_level, output ready);
endinterface

interface urm_out_if;
	logic        valid;
	logic        ready;
	logic        trigger_level;
	logic        busy_res;
	logic        done_res;
	logic        success;
	logic [15:0] echo_width_us;
	logic [16:0] distance_cm64;

	modport source (output valid, output trigger_level, output busy_res, output done_res,
		output success, output echo_width_us, output distance_cm64, input ready);
	modport sink   (input valid, input trigger_level, input busy_res, input done_res,
		input success, input echo_width_us, input distance_cm64, output ready);
endinterface

interface urm_cfg_if
	import urm_pkg::*;
	();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/ultrasonic_ranger_median.sv
// Top level of the ultrasonic ranger with median-of-samples filter.
//
//  channel  dir  handshake      payload
//  sample   in   valid/ready    req_type, echo_level (one item per microsecond tick)
//  result   out  valid/ready    trigger_level, busy_res, done_res, success,
//                               echo_width_us, distance_cm64 (one item per tick)
//  cfg      in   valid/ready    index, data (ready always high)
//
// One tick item is accepted per cycle while sample.ready is high; the sequencer
// state advances in that cycle. Each result passes the result register, then the
// distance multiply register; the two stages keep full rate while result.ready is high.
// Reset returns the sequencer to idle and the registers to their defaults.
// A stalled result holds both stages; sample.ready drops only when both are full.
module ultrasonic_ranger_median
	import urm_pkg::*;
#(
	parameter int MAX_SAMPLES = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	urm_in_if.sink     sample,
	urm_out_if.source  result,
	urm_cfg_if.sink    cfg
);

	cfg_t regs;
	res_t res;
	logic step, pipe_ready;

	assign sample.ready = pipe_ready;
	assign step         = sample.valid && pipe_ready;

	urm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	urm_seq #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.req_type   (sample.req_type),
		.echo_level (sample.echo_level),
		.regs       (regs),
		.res        (res)
	);

	urm_out_pipe u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step),
		.res_in (res),
		.ready  (pipe_ready),
		.result (result)
	);

endmodule

### rtl/urm_cfg_regs.sv
// Configuration register file of the ranger.
module urm_cfg_regs
	import urm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	urm_cfg_if.sink   cfg,
	output cfg_t      regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.timeout_us     <= 16'd30000;
			regs_q.trig_high_us   <= 8'd12;
			regs_q.gap_us         <= 17'd60000;
			regs_q.min_width_us   <= 16'd117;
			regs_q.max_width_us   <= 16'd23323;
			regs_q.samples_wanted <= 2'd3;
			regs_q.max_attempts   <= 4'd5;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_TIMEOUT:   regs_q.timeout_us     <= cfg.data[15:0];
				REG_TRIG_HIGH: regs_q.trig_high_us   <= cfg.data[7:0];
				REG_GAP:       regs_q.gap_us         <= cfg.data[16:0];
				REG_MIN_WIDTH: regs_q.min_width_us   <= cfg.data[15:0];
				REG_MAX_WIDTH: regs_q.max_width_us   <= cfg.data[15:0];
				REG_SAMPLES:   regs_q.samples_wanted <= cfg.data[1:0];
				REG_ATTEMPTS:  regs_q.max_attempts   <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

endmodule

### rtl/urm_seq.sv
// Measurement sequencer: trigger timing, echo capture, sorted sample store, median pick.
module urm_seq
	import urm_pkg::*;
#(
	parameter int MAX_SAMPLES = 3
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic req_type,
	input  logic echo_level,
	input  cfg_t regs,
	output res_t res
);

	localparam int VC_W  = $clog2(MAX_SAMPLES + 1);
	localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

	phase_t              phase_q, phase_d;
	logic [TICK_W-1:0]   tick_q, tick_d, tick_inc;
	logic [VC_W-1:0]     vc_q, vc_d, target;
	logic [3:0]          att_q, att_d, att_inc, att_use;
	logic [WIDTH_W-1:0]  store_q [MAX_SAMPLES];
	logic [WIDTH_W-1:0]  store_ins [MAX_SAMPLES];
	logic [WIDTH_W-1:0]  store_nx [MAX_SAMPLES];
	logic [WIDTH_W-1:0]  new_w;
	logic [IDX_W-1:0]    med_idx;
	logic                ins, end_att, next_att, fin, trig, busy;

	assign tick_inc = tick_q + 1'b1;
	assign att_inc  = att_q + 1'b1;
	assign new_w    = tick_inc[WIDTH_W-1:0];
	assign target   = (32'(regs.samples_wanted) > MAX_SAMPLES) ? VC_W'(MAX_SAMPLES)
		: VC_W'(regs.samples_wanted);

	// insert the new width so the store stays sorted ascending
	always_comb begin
		for (int i = 0; i < MAX_SAMPLES; i++) begin
			if (i > 0 && VC_W'(i - 1) < vc_q && store_q[(i > 0) ? i - 1 : 0] > new_w) begin
				store_ins[i] = store_q[(i > 0) ? i - 1 : 0];
			end else if (VC_W'(i) < vc_q && store_q[i] <= new_w) begin
				store_ins[i] = store_q[i];
			end else begin
				store_ins[i] = new_w;
			end
			store_nx[i] = ins ? store_ins[i] : store_q[i];
		end
	end

	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		vc_d     = vc_q;
		att_d    = att_q;
		ins      = 1'b0;
		end_att  = 1'b0;
		next_att = 1'b0;
		fin      = 1'b0;
		trig     = 1'b0;
		busy     = 1'b1;
		case (phase_q)
			PH_IDLE: begin
				if (!req_type) begin
					busy = 1'b0;
				end else begin
					vc_d  = '0;
					att_d = '0;
					if (regs.max_attempts == 4'd0 || target == '0) begin
						fin = 1'b1;
					end else begin
						phase_d = PH_TLOW;
						tick_d  = TICK_W'(1);
					end
				end
			end
			PH_TLOW: begin
				tick_d = tick_inc;
				if (tick_inc >= TRIG_LOW_TICKS) begin
					phase_d = PH_THIGH;
					tick_d  = '0;
				end
			end
			PH_THIGH: begin
				trig   = 1'b1;
				tick_d = tick_inc;
				if (tick_inc >= {9'd0, regs.trig_high_us}) begin
					phase_d = PH_RISE;
					tick_d  = '0;
				end
			end
			PH_RISE: begin
				if (echo_level) begin
					phase_d = PH_FALL;
					tick_d  = '0;
				end else if (tick_q >= {1'b0, regs.timeout_us}) begin
					end_att = 1'b1;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_FALL: begin
				tick_d = tick_inc;
				if (!echo_level) begin
					if (tick_inc >= {1'b0, regs.min_width_us}
							&& tick_inc <= {1'b0, regs.max_width_us}
							&& vc_q < VC_W'(MAX_SAMPLES)) begin
						ins  = 1'b1;
						vc_d = vc_q + 1'b1;
					end
					end_att = 1'b1;
				end else if (tick_inc >= {1'b0, regs.timeout_us}) begin
					end_att = 1'b1;
				end
			end
			PH_GAP: begin
				tick_d = tick_inc;
				if (tick_inc >= regs.gap_us) begin
					next_att = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				tick_d  = '0;
				busy    = 1'b0;
			end
		endcase

		att_use = att_q;
		if (end_att) begin
			att_d   = att_inc;
			att_use = att_inc;
			tick_d  = '0;
			if (att_inc < regs.max_attempts && regs.gap_us != '0) begin
				phase_d = PH_GAP;
			end else begin
				next_att = 1'b1;
			end
		end
		if (next_att) begin
			tick_d = '0;
			if (att_use >= regs.max_attempts || vc_d >= target) begin
				fin = 1'b1;
			end else begin
				phase_d = PH_TLOW;
			end
		end
		if (fin) begin
			phase_d = PH_IDLE;
			tick_d  = '0;
			busy    = 1'b0;
		end
	end

	assign med_idx = IDX_W'(vc_d >> 1);

	always_comb begin
		res.trigger_level = trig;
		res.busy_res      = busy;
		res.done_res      = fin;
		res.success       = fin && (vc_d != '0);
		res.echo_width_us = (fin && (vc_d != '0)) ? store_nx[med_idx] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			vc_q    <= '0;
			att_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			vc_q    <= vc_d;
			att_q   <= att_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && ins) begin
			for (int i = 0; i < MAX_SAMPLES; i++) begin
				store_q[i] <= store_ins[i];
			end
		end
	end

endmodule

### rtl/urm_out_pipe.sv
// Two-stage result pipeline: result register, then distance multiply register.
module urm_out_pipe
	import urm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  res_t       res_in,
	output logic       ready,
	urm_out_if.source  result
);

	logic                  valid_s1, valid_s2, take_s1;
	res_t                  res_s1, res_s2;
	logic [DIST_W-1:0]     dist_s2;
	logic [WIDTH_W+16:0]   prod;

	assign take_s1 = !valid_s2 || result.ready;
	assign ready   = !valid_s1 || take_s1;
	assign prod    = {17'd0, res_s1.echo_width_us} * {{WIDTH_W{1'b0}}, DIST_MUL};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready) begin
				valid_s1 <= load;
			end
			if (take_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			res_s1 <= res_in;
		end
		if (take_s1 && valid_s1) begin
			res_s2  <= res_s1;
			dist_s2 <= prod[DIST_SHIFT +: DIST_W];
		end
	end

	assign result.valid         = valid_s2;
	assign result.trigger_level = res_s2.trigger_level;
	assign result.busy_res      = res_s2.busy_res;
	assign result.done_res      = res_s2.done_res;
	assign result.success       = res_s2.success;
	assign result.echo_width_us = res_s2.echo_width_us;
	assign result.distance_cm64 = dist_s2;

endmodule

### rtl/urm_checker.sv
// Port-level checks on the ranger result channel, bound to the top level.
module urm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic        trigger_level,
	input logic        busy_res,
	input logic        done_res,
	input logic        success,
	input logic [15:0] echo_width_us,
	input logic [16:0] distance_cm64
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid && done_res |-> !busy_res && !trigger_level)
		else $error("done item shows busy or trigger");

	a_not_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !done_res |-> !success && echo_width_us == 16'd0 && distance_cm64 == 17'd0)
		else $error("result fields set on a tick without done");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && done_res && !success |-> echo_width_us == 16'd0 && distance_cm64 == 17'd0)
		else $error("failed measurement carries a width");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(done_res) && $stable(echo_width_us)
			&& $stable(distance_cm64))
		else $error("stalled result item changed");

endmodule

bind ultrasonic_ranger_median urm_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.valid         (result.valid),
	.ready         (result.ready),
	.trigger_level (result.trigger_level),
	.busy_res      (result.busy_res),
	.done_res      (result.done_res),
	.success       (result.success),
	.echo_width_us (result.echo_width_us),
	.distance_cm64 (result.distance_cm64)
);

### dv/tb.sv
// Ranger testbench: scripted and random tick streams checked against script rows and a tick model.
module tb;
	import urm_pkg::*;

	localparam int SAMPLE_SLOTS = 3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic        trig;
		logic        busy;
		logic        done;
		logic        ok;
		logic [15:0] width;
		logic [16:0] dist64;
	} reading_t;

	typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  rq;
		logic                  ec;
		logic                  typed;
		reading_t              want;
	} script_row_t;

	localparam reading_t RD_NONE  = '0;
	localparam reading_t RD_FAIL  = '{trig: 1'b0, busy: 1'b0, done: 1'b1, ok: 1'b0,
		width: 16'd0, dist64: 17'd0};
	localparam reading_t RD_START = '{trig: 1'b0, busy: 1'b1, done: 1'b0, ok: 1'b0,
		width: 16'd0, dist64: 17'd0};
	localparam reading_t RD_PULSE = '{trig: 1'b1, busy: 1'b1, done: 1'b0, ok: 1'b0,
		width: 16'd0, dist64: 17'd0};
	localparam reading_t RD_TWO   = '{trig: 1'b0, busy: 1'b0, done: 1'b1, ok: 1'b1,
		width: 16'd2, dist64: 17'd2};

	localparam int SCRIPT_ROWS = 36;
	localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b0, 1'b0, 1'b1, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b0, 1'b1, 1'b1, RD_NONE},
		'{ROW_REG,  REG_ATTEMPTS,  17'd0,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b1, 1'b0, 1'b1, RD_FAIL},
		'{ROW_REG,  REG_ATTEMPTS,  17'd1,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_REG,  REG_SAMPLES,   17'd0,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b1, 1'b1, 1'b1, RD_FAIL},
		'{ROW_REG,  REG_SAMPLES,   17'd1,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_REG,  REG_TIMEOUT,   17'd3,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_REG,  REG_TRIG_HIGH, 17'd0,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_REG,  REG_GAP,       17'd0,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_REG,  REG_MIN_WIDTH, 17'd2,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_REG,  REG_MAX_WIDTH, 17'd65535,   1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b1, 1'b0, 1'b1, RD_START},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b1, 1'b0, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b0, 1'b0, 1'b1, RD_PULSE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b0, 1'b1, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b0, 1'b1, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b0, 1'b0, 1'b1, RD_TWO},
		'{ROW_REG,  REG_UNUSED,    17'h1FFFF,   1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_REG,  REG_TIMEOUT,   17'h10001,   1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_REG,  REG_MAX_WIDTH, 17'd0,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_REG,  REG_SAMPLES,   17'd3,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_REG,  REG_ATTEMPTS,  17'd2,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_REG,  REG_GAP,       17'd1,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b1, 1'b0, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b0, 1'b1, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b0, 1'b1, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b1, 1'b0, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b0, 1'b0, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b0, 1'b1, 1'b0, RD_NONE},
		'{ROW_TICK, REG_TIMEOUT,   17'd0,       1'b0, 1'b1, 1'b1, RD_FAIL}
	};

	logic clk;
	logic arst_n;

	urm_in_if  sample_ch ();
	urm_out_if result_ch ();
	urm_cfg_if reg_ch ();

	ultrasonic_ranger_median #(
		.MAX_SAMPLES(SAMPLE_SLOTS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.cfg   (reg_ch)
	);

	// tick model state and register copy
	cfg_t        cset;
	phase_t      ph;
	logic [16:0] tcnt;
	logic [15:0] wstore [SAMPLE_SLOTS];
	int unsigned nvalid;
	int unsigned natt;

	reading_t    due_readings [$];
	int          bad_items;
	int          live_ticks;
	int          tx_idle_pct;
	int          rx_stall_pct;
	int          hold_asked;
	int          hold_served;

	// echo shaping
	phase_t      seen_ph;
	bit          noisy;
	int unsigned echo_delay;
	int unsigned echo_len;
	int unsigned burst_pos;
	int unsigned force_len;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int unsigned want_count();
		return (cset.samples_wanted > SAMPLE_SLOTS) ? SAMPLE_SLOTS : cset.samples_wanted;
	endfunction

	function automatic void wrap_up(inout reading_t r);
		logic [15:0] s [SAMPLE_SLOTS];
		logic [15:0] t;
		logic [15:0] w;
		int unsigned i;
		int unsigned j;
		ph = PH_IDLE;
		tcnt = '0;
		r.busy = 1'b0;
		r.done = 1'b1;
		if (nvalid == 0 || nvalid > SAMPLE_SLOTS) begin
			r.ok = 1'b0;
			r.width = '0;
			r.dist64 = '0;
			return;
		end
		for (i = 0; i < nvalid; i++)
			s[i] = wstore[i];
		for (i = 0; i + 1 < nvalid; i++)
			for (j = i + 1; j < nvalid; j++)
				if (s[j] < s[i]) begin
					t = s[i];
					s[i] = s[j];
					s[j] = t;
				end
		w = s[nvalid / 2];
		r.ok = 1'b1;
		r.width = w;
		r.dist64 = 17'((34'(w) * 34'd71930) >> 16);
	endfunction

	function automatic void next_or_wrap(inout reading_t r);
		if (natt >= cset.max_attempts || nvalid >= want_count()) begin
			wrap_up(r);
		end else begin
			ph = PH_TLOW;
			tcnt = '0;
		end
	endfunction

	function automatic void close_attempt(inout reading_t r);
		natt = (natt + 1) & 15;
		if (natt < cset.max_attempts && cset.gap_us != 0) begin
			ph = PH_GAP;
			tcnt = '0;
		end else begin
			next_or_wrap(r);
		end
	endfunction

	function automatic reading_t ranger_tick(logic rq, logic ec);
		reading_t r;
		r = '0;
		r.busy = 1'b1;
		if (ph == PH_IDLE) begin
			if (!rq) begin
				r.busy = 1'b0;
				return r;
			end
			nvalid = 0;
			natt = 0;
			tcnt = '0;
			if (cset.max_attempts == 0 || want_count() == 0) begin
				wrap_up(r);
				return r;
			end
			ph = PH_TLOW;
		end
		case (ph)
			PH_TLOW: begin
				tcnt = tcnt + 1'b1;
				if (tcnt >= 17'd2) begin
					ph = PH_THIGH;
					tcnt = '0;
				end
			end
			PH_THIGH: begin
				r.trig = 1'b1;
				tcnt = tcnt + 1'b1;
				if (tcnt >= cset.trig_high_us) begin
					ph = PH_RISE;
					tcnt = '0;
				end
			end
			PH_RISE: begin
				if (ec) begin
					ph = PH_FALL;
					tcnt = '0;
				end else if (tcnt >= cset.timeout_us) begin
					close_attempt(r);
				end else begin
					tcnt = tcnt + 1'b1;
				end
			end
			PH_FALL: begin
				tcnt = tcnt + 1'b1;
				if (!ec) begin
					if (tcnt >= cset.min_width_us && tcnt <= cset.max_width_us &&
						nvalid < SAMPLE_SLOTS) begin
						wstore[nvalid] = tcnt[15:0];
						nvalid++;
					end
					close_attempt(r);
				end else if (tcnt >= cset.timeout_us) begin
					close_attempt(r);
				end
			end
			PH_GAP: begin
				tcnt = tcnt + 1'b1;
				if (tcnt >= cset.gap_us)
					next_or_wrap(r);
			end
			default: begin
				ph = PH_IDLE;
				tcnt = '0;
				r.busy = 1'b0;
			end
		endcase
		return r;
	endfunction

	task automatic send_tick(input logic rq, input logic ec, input logic typed,
		input reading_t want);
		reading_t got;
		while ($urandom_range(99) < tx_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid      <= 1'b1;
		sample_ch.req_type   <= rq;
		sample_ch.echo_level <= ec;
		do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
		if (ph != PH_IDLE || rq)
			live_ticks++;
		got = ranger_tick(rq, ec);
		due_readings.push_back(typed ? want : got);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		reg_ch.valid <= 1'b1;
		reg_ch.index <= idx;
		reg_ch.data  <= data;
		do @(posedge clk); while (!(reg_ch.valid && reg_ch.ready));
		case (idx)
			REG_TIMEOUT:   cset.timeout_us     = data[15:0];
			REG_TRIG_HIGH: cset.trig_high_us   = data[7:0];
			REG_GAP:       cset.gap_us         = data[16:0];
			REG_MIN_WIDTH: cset.min_width_us   = data[15:0];
			REG_MAX_WIDTH: cset.max_width_us   = data[15:0];
			REG_SAMPLES:   cset.samples_wanted = data[1:0];
			REG_ATTEMPTS:  cset.max_attempts   = data[3:0];
			default: ;
		endcase
		reg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_readings();
		sample_ch.valid <= 1'b0;
		while (due_readings.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic pick_settings();
		int unsigned mn;
		mn = $urandom_range(8, 0);
		write_reg(REG_TIMEOUT, CFG_DATA_W'($urandom_range(24, 1)));
		write_reg(REG_TRIG_HIGH, CFG_DATA_W'($urandom_range(4, 0)));
		write_reg(REG_GAP, CFG_DATA_W'(($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1)));
		write_reg(REG_MIN_WIDTH, CFG_DATA_W'(mn));
		write_reg(REG_MAX_WIDTH, CFG_DATA_W'(($urandom_range(9) == 0) ?
			$urandom_range(mn, 0) : mn + $urandom_range(20, 0)));
		write_reg(REG_SAMPLES, CFG_DATA_W'(($urandom_range(7) == 0) ? 0 :
			$urandom_range(3, 1)));
		write_reg(REG_ATTEMPTS, CFG_DATA_W'(($urandom_range(6) == 0) ?
			$urandom_range(15, 0) : $urandom_range(4, 1)));
	endtask

	task automatic stim_next(output logic rq, output logic ec, input bit allow_start);
		int unsigned to;
		int unsigned lo;
		int unsigned hi;
		int unsigned sel;
		if (ph == PH_RISE && seen_ph != PH_RISE) begin
			burst_pos = 0;
			if (force_len != 0) begin
				noisy = 1'b0;
				echo_delay = 2;
				echo_len = force_len;
			end else begin
				noisy = ($urandom_range(99) < 12);
				to = cset.timeout_us;
				lo = (cset.min_width_us > 1) ? cset.min_width_us : 1;
				hi = (cset.max_width_us < to) ? cset.max_width_us : to;
				if (hi < lo)
					hi = lo;
				echo_delay = ($urandom_range(99) < 10) ? to + 1 + $urandom_range(2) :
					$urandom_range(to, 0);
				sel = $urandom_range(99);
				if (sel < 60)
					echo_len = $urandom_range(hi, lo);
				else if (sel < 75)
					echo_len = (cset.min_width_us > 1) ?
						$urandom_range(cset.min_width_us - 1, 1) : lo;
				else if (sel < 90)
					echo_len = cset.max_width_us + 1 + $urandom_range(3);
				else
					echo_len = to + $urandom_range(3);
			end
		end else begin
			burst_pos++;
		end
		seen_ph = ph;
		if (ph == PH_RISE || ph == PH_FALL)
			ec = noisy ? 1'($urandom_range(1)) :
				(burst_pos >= echo_delay && burst_pos < echo_delay + echo_len);
		else
			ec = ($urandom_range(99) < 20);
		if (ph == PH_IDLE)
			rq = allow_start && ($urandom_range(99) < 40);
		else
			rq = ($urandom_range(99) < 10);
	endtask

	task automatic run_phase(input int quota, input int hold_at, input int pause_at);
		int   first;
		logic rq;
		logic ec;
		bit   held;
		bit   paused;
		first = live_ticks;
		held = 1'b0;
		paused = 1'b0;
		stim_next(rq, ec, 1'b1);
		while (live_ticks - first < quota) begin
			send_tick(rq, ec, 1'b0, RD_NONE);
			if (!held && hold_at >= 0 && live_ticks - first >= hold_at) begin
				held = 1'b1;
				hold_asked++;
			end
			if (!paused && pause_at >= 0 && live_ticks - first >= pause_at) begin
				paused = 1'b1;
				sample_ch.valid <= 1'b0;
				while (due_readings.size() != 0)
					@(posedge clk);
			end
			stim_next(rq, ec, 1'b1);
		end
		while (ph != PH_IDLE) begin
			send_tick(rq, ec, 1'b0, RD_NONE);
			stim_next(rq, ec, 1'b0);
		end
	endtask

	// result side: stall, long hold-off, compare against the oldest due reading
	initial begin
		int       hold_left;
		reading_t seen;
		reading_t want;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				seen = '{trig: result_ch.trigger_level, busy: result_ch.busy_res,
					done: result_ch.done_res, ok: result_ch.success,
					width: result_ch.echo_width_us, dist64: result_ch.distance_cm64};
				if (due_readings.size() == 0) begin
					bad_items++;
					if (bad_items <= 30)
						$display("%0t: result item with none due: trig=%0b busy=%0b done=%0b ok=%0b width=%0d dist=%0d",
							$time, seen.trig, seen.busy, seen.done, seen.ok, seen.width,
							seen.dist64);
				end else begin
					want = due_readings.pop_front();
					if (seen.trig !== want.trig || seen.busy !== want.busy ||
						seen.done !== want.done || seen.ok !== want.ok ||
						seen.width !== want.width || seen.dist64 !== want.dist64) begin
						bad_items++;
						if (bad_items <= 30)
							$display("%0t: expected trig=%0b busy=%0b done=%0b ok=%0b width=%0d dist=%0d, actual trig=%0b busy=%0b done=%0b ok=%0b width=%0d dist=%0d",
								$time, want.trig, want.busy, want.done, want.ok, want.width,
								want.dist64, seen.trig, seen.busy, seen.done, seen.ok,
								seen.width, seen.dist64);
					end
				end
			end
			if (hold_served < hold_asked) begin
				hold_served++;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	initial begin
		cset = '{timeout_us: 16'd30000, trig_high_us: 8'd12, gap_us: 17'd60000,
			min_width_us: 16'd117, max_width_us: 16'd23323, samples_wanted: 2'd3,
			max_attempts: 4'd5};
		ph = PH_IDLE;
		seen_ph = PH_IDLE;
		tcnt = '0;
		for (int i = 0; i < SAMPLE_SLOTS; i++)
			wstore[i] = '0;
		nvalid = 0;
		natt = 0;
		bad_items = 0;
		live_ticks = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_asked = 0;
		hold_served = 0;
		noisy = 1'b0;
		echo_delay = 0;
		echo_len = 0;
		burst_pos = 0;
		force_len = 0;

		arst_n               <= 1'b0;
		sample_ch.valid      <= 1'b0;
		sample_ch.req_type   <= 1'b0;
		sample_ch.echo_level <= 1'b0;
		reg_ch.valid         <= 1'b0;
		reg_ch.index         <= REG_TIMEOUT;
		reg_ch.data          <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < SCRIPT_ROWS; k++) begin
			if (SCRIPT[k].kind == ROW_REG) begin
				drain_readings();
				write_reg(SCRIPT[k].idx, SCRIPT[k].data);
			end else begin
				send_tick(SCRIPT[k].rq, SCRIPT[k].ec, SCRIPT[k].typed, SCRIPT[k].want);
			end
		end
		drain_readings();

		for (int p = 0; p < 5; p++) begin
			pick_settings();
			case (p)
				1: begin
					tx_idle_pct = 59;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 59;
				end
				3: begin
					tx_idle_pct = 10;
					rx_stall_pct = 10;
				end
				default: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
			endcase
			run_phase(250, (p == 2) ? 100 : -1, (p == 4) ? 150 : -1);
			drain_readings();
		end

		// longest trigger pulse, widest timeout and width limits
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		write_reg(REG_TIMEOUT, 17'h1FFFF);
		write_reg(REG_TRIG_HIGH, 17'd255);
		write_reg(REG_GAP, 17'd120);
		write_reg(REG_MIN_WIDTH, 17'd0);
		write_reg(REG_MAX_WIDTH, 17'd65535);
		write_reg(REG_SAMPLES, 17'd1);
		write_reg(REG_ATTEMPTS, 17'd2);
		force_len = 60;
		run_phase(1, -1, -1);
		force_len = 0;
		drain_readings();

		// zero timeout, pulse and gap with the most attempts
		write_reg(REG_TIMEOUT, 17'd0);
		write_reg(REG_TRIG_HIGH, 17'd0);
		write_reg(REG_GAP, 17'd0);
		write_reg(REG_SAMPLES, 17'd3);
		write_reg(REG_ATTEMPTS, 17'd15);
		tx_idle_pct = 10;
		rx_stall_pct = 10;
		run_phase(100, -1, -1);
		drain_readings();

		repeat (5) @(posedge clk);
		if (bad_items == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### ultrasonic_ranger_median.f
rtl/urm_pkg.sv
rtl/urm_if.sv
rtl/urm_cfg_regs.sv
rtl/urm_seq.sv
rtl/urm_out_pipe.sv
rtl/ultrasonic_ranger_median.sv
rtl/urm_checker.sv
dv/tb.sv
